/* hdl/bvhmp_pkg.sv */
// Shared constants and register codes for the BVH midpoint partition block.
`default_nettype none

package bvhmp_pkg;

	localparam int MAX_ITEMS_DEF = 64;

	localparam int ID_W       = 16;
	localparam int COORD_W    = 32;
	localparam int AXIS_W     = 2;
	localparam int BASE_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Axis select codes
	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SPLIT_AXIS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPLIT_COORD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_INDEX  = 2'd2;

endpackage

`default_nettype wire

/* hdl/bvhmp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bvhmp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* hdl/bvh_midpoint_partition_top.sv */
// Top level of the BVH midpoint partition block: id store, swap sequencer, emission.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------------------
//  config   | in        | cfg_wr_en             | cfg_index, cfg_data
//  input    | in        | in_valid / in_stall   | item_id, box_min_*, box_max_*, last_item
//  output   | out       | out_valid / out_stall | out_id, split_index, overflowed, last_out
//
// A box that stays in place, or that passes with the front region touching the
// loaded region, is written while idle; a passing box that needs a swap is sequenced
// (read old front id, write new id to front, write old id to the tail) as set by the
// single read and single write port of the id RAM.
// On last_item, emission reads the first id, then loads and presents the ids in order.
// in_stall is high in every state but idle; out_stall holds the current item.
// arst_n clears counters, overflow flag, config registers and the sequencer; the id
// RAM is not cleared and no entry is read before it is written.
`default_nettype none

module bvh_midpoint_partition_top #(
	parameter int MAX_ITEMS = bvhmp_pkg::MAX_ITEMS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration
	input  wire logic                                cfg_wr_en,
	input  wire logic [bvhmp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [bvhmp_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input items
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [bvhmp_pkg::ID_W-1:0]          item_id,
	input  wire logic signed [bvhmp_pkg::COORD_W-1:0] box_min_x,
	input  wire logic signed [bvhmp_pkg::COORD_W-1:0] box_min_y,
	input  wire logic signed [bvhmp_pkg::COORD_W-1:0] box_min_z,
	input  wire logic signed [bvhmp_pkg::COORD_W-1:0] box_max_x,
	input  wire logic signed [bvhmp_pkg::COORD_W-1:0] box_max_y,
	input  wire logic signed [bvhmp_pkg::COORD_W-1:0] box_max_z,
	input  wire logic                                last_item,
	// result items
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic      [bvhmp_pkg::ID_W-1:0]          out_id,
	output logic      [bvhmp_pkg::BASE_W-1:0]        split_index,
	output logic                                     overflowed,
	output logic                                     last_out
);

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int SW = bvhmp_pkg::COORD_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWAP_FRONT,
		ST_SWAP_LOAD,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMIT_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [bvhmp_pkg::AXIS_W-1:0]         split_axis_q;
	logic signed [bvhmp_pkg::COORD_W-1:0] split_coord_q;
	logic [bvhmp_pkg::BASE_W-1:0]         base_index_q;

	// range state
	logic [CW-1:0]              loaded_q;
	logic [CW-1:0]              front_q;
	logic                       ovf_q;
	logic                       last_q;
	logic [bvhmp_pkg::ID_W-1:0] held_id_q;
	logic [AW-1:0]              k_q;

	// output register
	logic                         out_valid_q;
	logic [bvhmp_pkg::ID_W-1:0]   out_id_q;
	logic [bvhmp_pkg::BASE_W-1:0] split_index_q;
	logic                         overflowed_q;
	logic                         last_out_q;

	// RAM ports
	logic                       ram_wr_en;
	logic [AW-1:0]              ram_wr_addr;
	logic [bvhmp_pkg::ID_W-1:0] ram_wr_data;
	logic                       ram_rd_en;
	logic [AW-1:0]              ram_rd_addr;
	logic [bvhmp_pkg::ID_W-1:0] ram_rd_data;

	logic                         accept;
	logic                         full;
	logic                         front_behind;
	logic                         pass;
	logic signed [SW-1:0]         sum_lo_hi;
	logic signed [SW-1:0]         mid2;
	logic signed [bvhmp_pkg::COORD_W-1:0] sel_lo;
	logic signed [bvhmp_pkg::COORD_W-1:0] sel_hi;
	logic                         axis_ok;
	logic [CW-1:0]                split_pos;
	logic [bvhmp_pkg::BASE_W-1:0] split_calc;
	logic                         emit_last;

	assign in_stall    = (state_q != ST_IDLE);
	assign accept      = in_valid && !in_stall;
	assign full        = (loaded_q == CW'(MAX_ITEMS));
	assign front_behind = (front_q < loaded_q);

	// Axis select; the unused code lets nothing pass.
	always_comb begin
		sel_lo  = box_min_x;
		sel_hi  = box_max_x;
		axis_ok = 1'b1;
		case (split_axis_q)
			bvhmp_pkg::AXIS_X: begin
				sel_lo = box_min_x;
				sel_hi = box_max_x;
			end
			bvhmp_pkg::AXIS_Y: begin
				sel_lo = box_min_y;
				sel_hi = box_max_y;
			end
			bvhmp_pkg::AXIS_Z: begin
				sel_lo = box_min_z;
				sel_hi = box_max_z;
			end
			default: begin
				axis_ok = 1'b0;
			end
		endcase
	end

	// Exact centroid test: min + max < 2 * midpoint, all in 33 bits.
	assign sum_lo_hi = SW'(sel_lo) + SW'(sel_hi);
	assign mid2      = {split_coord_q, 1'b0};
	assign pass      = axis_ok && (sum_lo_hi < mid2);

	// Split falls back to half the count when all or none of the boxes passed.
	assign split_pos  = ((front_q == '0) || (front_q == loaded_q)) ? (loaded_q >> 1) : front_q;
	assign split_calc = base_index_q + bvhmp_pkg::BASE_W'(split_pos);
	assign emit_last  = ((CW'(k_q) + CW'(1)) == loaded_q);

	// RAM access per state
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = front_q[AW-1:0];
		ram_wr_data = item_id;
		ram_rd_en   = 1'b0;
		ram_rd_addr = front_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept && !full) begin
					if (pass && front_behind) begin
						ram_rd_en   = 1'b1;
						ram_rd_addr = front_q[AW-1:0];
					end else begin
						ram_wr_en   = 1'b1;
						ram_wr_addr = pass ? front_q[AW-1:0] : loaded_q[AW-1:0];
						ram_wr_data = item_id;
					end
				end
			end
			ST_SWAP_FRONT: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = front_q[AW-1:0];
				ram_wr_data = held_id_q;
			end
			ST_SWAP_LOAD: begin
				// old front id moves to the tail
				ram_wr_en   = 1'b1;
				ram_wr_addr = loaded_q[AW-1:0];
				ram_wr_data = ram_rd_data;
			end
			ST_EMIT_RD: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = k_q;
			end
			ST_EMIT_OUT: begin
				// prefetch the next id as the current one leaves
				if (!out_stall && !last_out_q) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = AW'(k_q + AW'(1));
				end
			end
			default: begin
				ram_wr_en = 1'b0;
				ram_rd_en = 1'b0;
			end
		endcase
	end

	bvhmp_ram #(
		.WIDTH (bvhmp_pkg::ID_W),
		.DEPTH (1 << AW)
	) u_id_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_axis_q  <= bvhmp_pkg::AXIS_X;
			split_coord_q <= '0;
			base_index_q  <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bvhmp_pkg::REG_SPLIT_AXIS: begin
					split_axis_q <= cfg_data[bvhmp_pkg::AXIS_W-1:0];
				end
				bvhmp_pkg::REG_SPLIT_COORD: begin
					split_coord_q <= cfg_data;
				end
				bvhmp_pkg::REG_BASE_INDEX: begin
					base_index_q <= cfg_data[bvhmp_pkg::BASE_W-1:0];
				end
				default: begin
					split_axis_q <= split_axis_q;
				end
			endcase
		end
	end

	// Sequencer, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			loaded_q      <= '0;
			front_q       <= '0;
			ovf_q         <= 1'b0;
			last_q        <= 1'b0;
			held_id_q     <= '0;
			k_q           <= '0;
			out_valid_q   <= 1'b0;
			out_id_q      <= '0;
			split_index_q <= '0;
			overflowed_q  <= 1'b0;
			last_out_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (accept) begin
						last_q <= last_item;
						if (full) begin
							ovf_q <= 1'b1;
							if (last_item) begin
								state_q <= ST_EMIT_RD;
							end
						end else if (pass && front_behind) begin
							held_id_q <= item_id;
							state_q   <= ST_SWAP_FRONT;
						end else begin
							loaded_q <= loaded_q + CW'(1);
							if (pass) begin
								front_q <= front_q + CW'(1);
							end
							if (last_item) begin
								state_q <= ST_EMIT_RD;
							end
						end
					end
				end
				ST_SWAP_FRONT: begin
					state_q <= ST_SWAP_LOAD;
				end
				ST_SWAP_LOAD: begin
					loaded_q <= loaded_q + CW'(1);
					front_q  <= front_q + CW'(1);
					state_q  <= last_q ? ST_EMIT_RD : ST_IDLE;
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					out_valid_q   <= 1'b1;
					out_id_q      <= ram_rd_data;
					split_index_q <= split_calc;
					overflowed_q  <= ovf_q;
					last_out_q    <= emit_last;
					state_q       <= ST_EMIT_OUT;
				end
				ST_EMIT_OUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (last_out_q) begin
							loaded_q <= '0;
							front_q  <= '0;
							ovf_q    <= 1'b0;
							state_q  <= ST_IDLE;
						end else begin
							k_q     <= AW'(k_q + AW'(1));
							state_q <= ST_EMIT_LD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_id      = out_id_q;
	assign split_index = split_index_q;
	assign overflowed  = overflowed_q;
	assign last_out    = last_out_q;

`ifndef SYNTHESIS
	// front region never passes the loaded region
	a_front_le_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		front_q <= loaded_q)
		else $error("front count above loaded count");

	a_loaded_cap: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= CW'(MAX_ITEMS))
		else $error("loaded count above capacity");

	// no input is taken while a result is pending
	a_no_accept_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted during emission");

	// the final result of a run leaves the range empty
	a_clear_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_out && !out_stall) |=> (loaded_q == '0 && !ovf_q))
		else $error("range state not cleared after run");

	// a swap always ends in the tail write
	a_swap_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWAP_FRONT) |=> (state_q == ST_SWAP_LOAD))
		else $error("swap sequence broken");
`endif

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for bvh_midpoint_partition_top: predicted partition order vs emitted ids.
import bvhmp_pkg::*;

typedef struct packed {
	logic [ID_W-1:0]            id;
	logic [2:0][COORD_W-1:0]    lo;
	logic [2:0][COORD_W-1:0]    hi;
	logic                       last;
} box_t;

typedef struct packed {
	logic [ID_W-1:0]   id;
	logic [BASE_W-1:0] split;
	logic              ovf;
	logic              last;
} emitted_t;

class partition_tracker;
	logic [ID_W-1:0]           id_slots [MAX_ITEMS_DEF];
	int unsigned               loaded;
	int unsigned               front;
	bit                        dropped;
	logic [AXIS_W-1:0]         axis;
	logic signed [COORD_W-1:0] mid;
	logic [BASE_W-1:0]         base;
	emitted_t                  due_ids [$];
	int unsigned               errors;
	int unsigned               checked;
	int unsigned               boxes;
	int unsigned               ranges;
	int unsigned               overflow_runs;

	function new();
		loaded = 0;
		front = 0;
		dropped = 0;
		axis = AXIS_X;
		mid = '0;
		base = '0;
		errors = 0;
		checked = 0;
		boxes = 0;
		ranges = 0;
		overflow_runs = 0;
	endfunction

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_SPLIT_AXIS: axis = data[AXIS_W-1:0];
			REG_SPLIT_COORD: mid = data;
			REG_BASE_INDEX: base = data[BASE_W-1:0];
			default: ;
		endcase
	endfunction

	// exact centroid test: lo + hi < 2 * mid, carried out wide enough not to wrap
	function bit centroid_below(box_t b);
		longint lo_v;
		longint hi_v;
		if (axis > AXIS_Z)
			return 1'b0;
		lo_v = longint'($signed(b.lo[axis]));
		hi_v = longint'($signed(b.hi[axis]));
		return (lo_v + hi_v) < 2 * longint'(mid);
	endfunction

	function void take_box(box_t b);
		int unsigned cut;
		emitted_t e;
		boxes++;
		if (loaded < MAX_ITEMS_DEF) begin
			if (centroid_below(b)) begin
				if (front < loaded)
					id_slots[loaded] = id_slots[front];
				id_slots[front] = b.id;
				front++;
			end else begin
				id_slots[loaded] = b.id;
			end
			loaded++;
		end else begin
			dropped = 1'b1;
		end
		if (!b.last)
			return;
		cut = (front == 0 || front == loaded) ? loaded / 2 : front;
		for (int unsigned k = 0; k < loaded; k++) begin
			e.id = id_slots[k];
			e.split = BASE_W'(base + cut);
			e.ovf = dropped;
			e.last = (k + 1 == loaded);
			due_ids.push_back(e);
		end
		ranges++;
		if (dropped)
			overflow_runs++;
		loaded = 0;
		front = 0;
		dropped = 1'b0;
	endfunction

	function void match_emitted(emitted_t got);
		emitted_t want;
		if (due_ids.size() == 0) begin
			$error("unexpected result: out_id %0h split_index %0d", got.id, got.split);
			errors++;
			return;
		end
		want = due_ids.pop_front();
		checked++;
		if (got.id !== want.id) begin
			$error("out_id: expected %0h, got %0h", want.id, got.id);
			errors++;
		end
		if (got.split !== want.split) begin
			$error("split_index: expected %0d, got %0d", want.split, got.split);
			errors++;
		end
		if (got.ovf !== want.ovf) begin
			$error("overflowed: expected %0b, got %0b", want.ovf, got.ovf);
			errors++;
		end
		if (got.last !== want.last) begin
			$error("last_out: expected %0b, got %0b", want.last, got.last);
			errors++;
		end
	endfunction

	function int unsigned pending();
		return due_ids.size();
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// axis code the block treats as selecting nothing
	localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;
	localparam int unsigned STALL_LIMIT = 5000;  // cycles with no item moving
	localparam int unsigned SETTLE = 12;         // covers a trailing swap
	localparam int unsigned LONG_HOLD = 400;     // receiver back-pressure stretch
	localparam int unsigned BOX_TARGET = 135;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	box_t                    offered;
	logic                    out_valid;
	logic                    out_stall;
	logic [ID_W-1:0]         out_id;
	logic [BASE_W-1:0]       split_index;
	logic                    overflowed;
	logic                    last_out;

	partition_tracker tracker;
	int unsigned send_burst = 0;
	int unsigned recv_burst = 0;
	int unsigned long_hold = 0;  // set by the stimulus, consumed by the sink

	bvh_midpoint_partition_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.item_id     (offered.id),
		.box_min_x   (offered.lo[0]),
		.box_min_y   (offered.lo[1]),
		.box_min_z   (offered.lo[2]),
		.box_max_x   (offered.hi[0]),
		.box_max_y   (offered.hi[1]),
		.box_max_z   (offered.hi[2]),
		.last_item   (offered.last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_id      (out_id),
		.split_index (split_index),
		.overflowed  (overflowed),
		.last_out    (last_out)
	);

	always #5 clk = ~clk;

	// Idle cycles before the next item on one side: mostly a uniform random draw, with
	// occasional bursts of back-to-back items.
	function automatic int unsigned draw_gap(inout int unsigned burst);
		if (burst != 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 11);
	endfunction

	// Coordinate close to the midpoint so both outcomes are common; sometimes
	// anywhere in the full signed range.
	function automatic logic [COORD_W-1:0] near_mid();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return tracker.mid + $urandom_range(0, 1 << 21) - (1 << 20);
	endfunction

	function automatic box_t random_box(input bit last);
		box_t b;
		b.id = $urandom;
		b.last = last;
		for (int a = 0; a < 3; a++) begin
			b.lo[a] = near_mid();
			b.hi[a] = near_mid();
		end
		// land on the compare boundary: sum equal to twice the midpoint, or one below
		if (tracker.axis != AXIS_NONE && $urandom_range(0, 7) == 0)
			b.hi[tracker.axis] = (tracker.mid <<< 1) - b.lo[tracker.axis]
				- $urandom_range(0, 1);
		return b;
	endfunction

	// Box with the given corners on the selected axis (all axes when none is
	// selected) and noise elsewhere.
	function automatic box_t axis_box(input logic [ID_W-1:0] id,
			input logic [COORD_W-1:0] lo, input logic [COORD_W-1:0] hi, input bit last);
		box_t b;
		b.id = id;
		b.last = last;
		for (int a = 0; a < 3; a++) begin
			if (tracker.axis == a || tracker.axis == AXIS_NONE) begin
				b.lo[a] = lo;
				b.hi[a] = hi;
			end else begin
				b.lo[a] = $urandom;
				b.hi[a] = $urandom;
			end
		end
		return b;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		tracker.set_reg(idx, data);
	endtask

	task automatic program_regs(input logic [CFG_DATA_W-1:0] axis_word,
			input logic [CFG_DATA_W-1:0] coord_word, input logic [CFG_DATA_W-1:0] base_word);
		write_reg(REG_SPLIT_AXIS, axis_word);
		write_reg(REG_SPLIT_COORD, coord_word);
		write_reg(REG_BASE_INDEX, base_word);
	endtask

	// Present one item after a random gap and hold it until the block takes it.
	task automatic offer_box(input box_t b);
		int unsigned gap;
		gap = draw_gap(send_burst);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		offered <= b;
		do
			@(posedge clk);
		while (in_stall);
		tracker.take_box(b);
	endtask

	task automatic offer_range(input int unsigned count);
		for (int unsigned k = 0; k < count; k++)
			offer_box(random_box(k + 1 == count));
	endtask

	// Sender pause: drop valid, wait out every predicted id, then let the block
	// finish any trailing swap before registers may change.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
	endtask

	task automatic random_setup();
		logic [CFG_DATA_W-1:0] axis_word;
		logic [CFG_DATA_W-1:0] coord_word;
		logic [CFG_DATA_W-1:0] base_word;
		// junk in the unused upper bits must be ignored by the block
		axis_word = $urandom;
		case ($urandom_range(0, 9))
			0: axis_word[AXIS_W-1:0] = AXIS_NONE;
			1, 2, 3: axis_word[AXIS_W-1:0] = AXIS_X;
			4, 5, 6: axis_word[AXIS_W-1:0] = AXIS_Y;
			default: axis_word[AXIS_W-1:0] = AXIS_Z;
		endcase
		case ($urandom_range(0, 7))
			0: coord_word = 32'h8000_0000;
			1: coord_word = 32'h7FFF_FFFF;
			2: coord_word = $urandom;
			default: coord_word = $urandom_range(0, 1 << 24) - (1 << 23);
		endcase
		base_word = $urandom;
		case ($urandom_range(0, 5))
			0: base_word[BASE_W-1:0] = '0;
			1: base_word[BASE_W-1:0] = '1;
			2: base_word[BASE_W-1:0] = 16'd65471;
			default: ;
		endcase
		program_regs(axis_word, coord_word, base_word);
	endtask

	// Result sink: random stall before each item, plus one long hold on request.
	initial begin : result_sink
		int unsigned hold;
		emitted_t got;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold == 0 && long_hold != 0) begin
				hold = long_hold;
				long_hold = 0;
			end
			if (hold != 0) begin
				out_stall <= 1'b1;
				hold--;
			end else begin
				out_stall <= 1'b0;
			end
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got = {out_id, split_index, overflowed, last_out};
				tracker.match_emitted(got);
				hold = draw_gap(recv_burst);
			end
		end
	end

	// Watchdog: a hang shows up as a long run of cycles with nothing moving.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL bvh_midpoint_partition_top");
		$finish;
	end

	initial begin : stimulus
		int unsigned count;
		int unsigned nranges;
		int unsigned phase;
		tracker = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_SPLIT_AXIS;
		cfg_data = '0;
		in_valid = 1'b0;
		offered = '0;
		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// ---- directed part ----
		// x axis, midpoint 0: extremes and the equality boundary
		program_regs(CFG_DATA_W'(AXIS_X), 32'h0000_0000, 32'h0000_0000);
		// lone box that passes: all-pass fallback on a range of one
		offer_box(axis_box(16'h0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
		// mixed range, passing boxes after failing ones force swaps
		offer_box(axis_box(16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
		offer_box(axis_box(16'h0001, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0));
		offer_box(axis_box(16'h0002, 32'h0000_0000, 32'h0000_0000, 1'b0));
		offer_box(axis_box(16'h0003, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
		// min above max is taken as is
		offer_box(axis_box(16'h0004, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
		// nothing passes: split falls back to half the count
		offer_box(axis_box(16'hAAAA, 32'h0000_0001, 32'h0000_0001, 1'b0));
		offer_box(axis_box(16'h5555, 32'h0000_0001, 32'h0000_0001, 1'b0));
		offer_box(axis_box(16'h8001, 32'h0000_0001, 32'h0000_0001, 1'b1));
		drain_results();

		// y axis, highest midpoint, base index at its top so the split wraps
		program_regs(CFG_DATA_W'(AXIS_Y), 32'h7FFF_FFFF, 32'h0000_FFFF);
		offer_box(axis_box(16'h0010, 32'hFFFF_FFFB, 32'h0000_0003, 1'b0));
		offer_box(axis_box(16'h0011, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
		offer_box(axis_box(16'h0012, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 1'b1));
		offer_box(axis_box(16'h0020, 32'h0000_0000, 32'h0000_0000, 1'b0));
		offer_box(axis_box(16'h0021, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
		offer_box(axis_box(16'h0022, 32'h1234_5678, 32'h8765_4321, 1'b1));
		drain_results();

		// z axis, lowest midpoint: no box can get below it
		program_regs(CFG_DATA_W'(AXIS_Z), 32'h8000_0000, 32'h0000_FFBF);
		offer_box(axis_box(16'h0030, 32'h8000_0000, 32'h8000_0000, 1'b0));
		offer_box(axis_box(16'h0031, 32'h8000_0000, 32'h8000_0001, 1'b1));
		drain_results();

		// unused axis code: every box stays behind
		program_regs(CFG_DATA_W'(AXIS_NONE), 32'h0000_0000, 32'h0000_0007);
		offer_box(axis_box(16'h0040, 32'h8000_0000, 32'h8000_0000, 1'b0));
		offer_box(axis_box(16'h0041, 32'h8000_0000, 32'h8000_0000, 1'b0));
		offer_box(axis_box(16'h0042, 32'h8000_0000, 32'h8000_0000, 1'b1));

		// ---- random part ----
		// Each phase: drain, reprogram, then a few back-to-back ranges. The
		// overflow phase and the long-hold phase always run.
		phase = 0;
		while (tracker.boxes < BOX_TARGET || phase < 3) begin
			drain_results();
			random_setup();
			nranges = (phase == 2) ? 3 : $urandom_range(1, 4);
			for (int unsigned r = 0; r < nranges; r++) begin
				if (phase == 0 && r == 0) begin
					// past capacity: the last two boxes, the marked one included, are dropped
					count = MAX_ITEMS_DEF + 2;
				end else if (phase == 2 && r == 0) begin
					// short range emitted into a stalled sink while more boxes queue up
					long_hold = LONG_HOLD;
					count = 3;
				end else if ($urandom_range(0, 15) == 0) begin
					count = $urandom_range(MAX_ITEMS_DEF - 2, MAX_ITEMS_DEF + 2);
				end else begin
					count = $urandom_range(1, 10);
				end
				offer_range(count);
			end
			phase++;
		end

		drain_results();
		$display("Covered %0d boxes in %0d ranges (%0d past capacity), %0d ids checked.",
			tracker.boxes, tracker.ranges, tracker.overflow_runs, tracker.checked);
		$display("Axes x/y/z/unused, midpoint and base extremes, split wrap, long sink hold.");
		if (tracker.errors == 0) begin
			$display("PASS bvh_midpoint_partition_top");
		end else begin
			$display("FAIL bvh_midpoint_partition_top");
		end
		$finish;
	end
endmodule
